// ----- src/ngfe_pkg.sv -----
// Shared types and constants for the GGA sentence field extractor.
`timescale 1ns / 1ps

package ngfe_pkg;

   // Characters the parser looks for.
   localparam logic [7:0] CHAR_G     = 8'h47;
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   // Field widths of one result.
   localparam int TIME_W = 48;
   localparam int LAT_W  = 32;
   localparam int LON_W  = 40;
   localparam int CHAR_W = 8;

   // Number of digit bytes in each field.
   localparam int TIME_DIGITS = TIME_W / 8;
   localparam int LAT_DIGITS  = LAT_W / 8;
   localparam int LON_DIGITS  = LON_W / 8;

   // Record contents after reset.
   localparam logic [TIME_W-1:0] TIME_RESET = 48'h01_01_02_04_00_08;
   localparam logic [LAT_W-1:0]  LAT_RESET  = 32'h02_04_01_07;
   localparam logic [LON_W-1:0]  LON_RESET  = 40'h01_01_03_02_04;
   localparam logic [CHAR_W-1:0] NS_RESET   = 8'h4E;
   localparam logic [CHAR_W-1:0] EW_RESET   = 8'h45;

   // Command queue between the parser and the record store; depth is a power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_TIME,
      CMD_LAT,
      CMD_NS,
      CMD_LON,
      CMD_EW
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [2:0]   pos;
      logic [7:0]   value;
   } cmd_type;

endpackage

// ----- src/ngfe_if.sv -----
// Request and response channel interfaces of the GGA sentence field extractor.
`timescale 1ns / 1ps

interface ngfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface ngfe_rsp_if;
   logic        valid;
   logic        ready;
   logic [47:0] time_digits;
   logic [31:0] latitude_digits;
   logic [7:0]  north_south;
   logic [39:0] longitude_digits;
   logic [7:0]  east_west;
   logic        record_done;

   modport source (output valid, output time_digits, output latitude_digits,
                   output north_south, output longitude_digits, output east_west,
                   output record_done, input ready);
   modport sink (input valid, input time_digits, input latitude_digits,
                 input north_south, input longitude_digits, input east_west,
                 input record_done, output ready);
endinterface

// ----- src/ngfe_front.sv -----
// Sentence parser: tracks the position in the GGA sentence and turns each byte into a store command.
`timescale 1ns / 1ps

module ngfe_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            byte_valid,
   input  logic [7:0]      rx_byte,
   input  logic            cmd_ready,
   output ngfe_pkg::cmd_type cmd
);
   import ngfe_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_P,
      ST_G2,
      ST_G3,
      ST_A,
      ST_COMMA,
      ST_HOUR,
      ST_MIN,
      ST_SEC,
      ST_SKIP_LAT,
      ST_LAT,
      ST_SKIP_NS,
      ST_NS,
      ST_SKIP_BYTE,
      ST_LON,
      ST_SKIP_EW,
      ST_EW
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] index_ff, index_in;
   logic [2:0] index_next;
   logic [2:0] time_base;
   logic       accept;

   // A field ends once the advanced index passes its last digit or wraps to zero.
   function automatic logic field_end(input logic [2:0] nxt, input logic [2:0] last);
      return (nxt > last) || (nxt == 3'd0);
   endfunction

   assign accept     = byte_valid && cmd_ready;
   assign index_next = index_ff + 3'd1;

   always_comb begin
      state_in   = state_ff;
      index_in   = index_ff;
      time_base  = 3'd0;
      cmd.kind   = CMD_NONE;
      cmd.pos    = index_ff;
      cmd.value  = rx_byte - CHAR_ZERO;
      unique case (state_ff)
         ST_IDLE: begin
            if (rx_byte == CHAR_G) state_in = ST_P;
         end
         ST_P:     state_in = (rx_byte == CHAR_P) ? ST_G2 : ST_IDLE;
         ST_G2:    state_in = (rx_byte == CHAR_G) ? ST_G3 : ST_IDLE;
         ST_G3:    state_in = (rx_byte == CHAR_G) ? ST_A : ST_IDLE;
         ST_A:     state_in = (rx_byte == CHAR_A) ? ST_COMMA : ST_IDLE;
         ST_COMMA: state_in = (rx_byte == CHAR_COMMA) ? ST_HOUR : ST_IDLE;
         ST_HOUR, ST_MIN, ST_SEC: begin
            // Hours, minutes and seconds each take two digits of the time field.
            if (state_ff == ST_MIN) time_base = 3'd2;
            else if (state_ff == ST_SEC) time_base = 3'd4;
            if (index_ff < 3'd2) begin
               cmd.kind = CMD_TIME;
               cmd.pos  = time_base + {2'b00, index_ff[0]};
            end
            index_in = index_next;
            if (field_end(index_next, 3'd1)) begin
               index_in = 3'd0;
               if (state_ff == ST_HOUR) state_in = ST_MIN;
               else if (state_ff == ST_MIN) state_in = ST_SEC;
               else state_in = ST_SKIP_LAT;
            end
         end
         ST_SKIP_LAT: begin
            if (rx_byte == CHAR_COMMA) state_in = ST_LAT;
         end
         ST_LAT: begin
            cmd.kind = CMD_LAT;
            index_in = index_next;
            if (field_end(index_next, 3'(LAT_DIGITS - 1))) begin
               index_in = 3'd0;
               state_in = ST_SKIP_NS;
            end
         end
         ST_SKIP_NS: begin
            if (rx_byte == CHAR_COMMA) state_in = ST_NS;
         end
         ST_NS: begin
            cmd.kind  = CMD_NS;
            cmd.value = rx_byte;
            state_in  = ST_SKIP_BYTE;
         end
         ST_SKIP_BYTE: state_in = ST_LON;
         ST_LON: begin
            cmd.kind = CMD_LON;
            index_in = index_next;
            if (field_end(index_next, 3'(LON_DIGITS - 1))) begin
               index_in = 3'd0;
               state_in = ST_SKIP_EW;
            end
         end
         ST_SKIP_EW: begin
            if (rx_byte == CHAR_COMMA) state_in = ST_EW;
         end
         ST_EW: begin
            cmd.kind  = CMD_EW;
            cmd.value = rx_byte;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         index_ff <= 3'd0;
      end else if (accept) begin
         state_ff <= state_in;
         index_ff <= index_in;
      end
   end

endmodule

// ----- src/ngfe_queue.sv -----
// Short command queue that lets the parser and the record store stall independently.
`timescale 1ns / 1ps

module ngfe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  ngfe_pkg::cmd_type push_cmd,
   output logic              push_ready,
   output logic              pop_valid,
   output ngfe_pkg::cmd_type pop_cmd,
   input  logic              pop_ready
);
   import ngfe_pkg::*;

   cmd_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     push, pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + QUEUE_CNT_W'(1);
         2'b01:   count_in = count_ff - QUEUE_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

// ----- src/ngfe_back.sv -----
// Record store: applies store commands and presents the whole record as the response.
`timescale 1ns / 1ps

module ngfe_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  ngfe_pkg::cmd_type cmd,
   output logic              cmd_ready,
   ngfe_rsp_if.source        rsp_chan
);
   import ngfe_pkg::*;

   logic [TIME_W-1:0] time_ff, time_in;
   logic [LAT_W-1:0]  lat_ff, lat_in;
   logic [LON_W-1:0]  lon_ff, lon_in;
   logic [CHAR_W-1:0] ns_ff, ns_in;
   logic [CHAR_W-1:0] ew_ff, ew_in;
   logic              done_ff;
   logic              valid_ff;
   logic              load;

   // The stores themselves are the output register; a new command loads when the slot frees.
   assign cmd_ready = !valid_ff || rsp_chan.ready;
   assign load      = cmd_valid && cmd_ready;

   always_comb begin
      time_in = time_ff;
      lat_in  = lat_ff;
      lon_in  = lon_ff;
      ns_in   = ns_ff;
      ew_in   = ew_ff;
      unique case (cmd.kind)
         CMD_TIME: begin
            for (int i = 0; i < TIME_DIGITS; i++) begin
               if (cmd.pos == 3'(i)) time_in[8*(TIME_DIGITS-1-i) +: 8] = cmd.value;
            end
         end
         CMD_LAT: begin
            for (int i = 0; i < LAT_DIGITS; i++) begin
               if (cmd.pos == 3'(i)) lat_in[8*(LAT_DIGITS-1-i) +: 8] = cmd.value;
            end
         end
         CMD_LON: begin
            for (int i = 0; i < LON_DIGITS; i++) begin
               if (cmd.pos == 3'(i)) lon_in[8*(LON_DIGITS-1-i) +: 8] = cmd.value;
            end
         end
         CMD_NS:  ns_in = cmd.value;
         CMD_EW:  ew_in = cmd.value;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
         time_ff  <= TIME_RESET;
         lat_ff   <= LAT_RESET;
         lon_ff   <= LON_RESET;
         ns_ff    <= NS_RESET;
         ew_ff    <= EW_RESET;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            done_ff  <= (cmd.kind == CMD_EW);
            time_ff  <= time_in;
            lat_ff   <= lat_in;
            lon_ff   <= lon_in;
            ns_ff    <= ns_in;
            ew_ff    <= ew_in;
         end else if (rsp_chan.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid            = valid_ff;
   assign rsp_chan.time_digits      = time_ff;
   assign rsp_chan.latitude_digits  = lat_ff;
   assign rsp_chan.north_south      = ns_ff;
   assign rsp_chan.longitude_digits = lon_ff;
   assign rsp_chan.east_west        = ew_ff;
   assign rsp_chan.record_done      = done_ff;

endmodule

// ----- src/nmea_gga_field_extractor_core.sv -----
// Top level of the GGA sentence field extractor: parser, command queue and record store.
//
//   Channel    Direction  Carries
//   req_chan   in         one received character (rx_byte)
//   rsp_chan   out        the stored record after that character, plus record_done
//
// One character is taken per cycle and one response leaves per cycle when both sides flow.
// An accepted request is registered first in the four-entry command queue and then in the
// record store, which is the output register. The parser stalls only when the queue is
// full; the store drains the queue whenever its response has been taken or is empty.
// Synchronous reset restores the default record and empties the queue; requests are
// accepted from the first cycle after reset.
`timescale 1ns / 1ps

module nmea_gga_field_extractor_core (
   input  logic       clock,
   input  logic       reset,
   ngfe_req_if.sink   req_chan,
   ngfe_rsp_if.source rsp_chan
);
   import ngfe_pkg::*;

   cmd_type front_cmd;
   cmd_type back_cmd;
   logic    push_ready;
   logic    pop_valid;
   logic    pop_ready;

   assign req_chan.ready = push_ready;

   ngfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_chan.valid),
      .rx_byte    (req_chan.rx_byte),
      .cmd_ready  (push_ready),
      .cmd        (front_cmd)
   );

   ngfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_chan.valid),
      .push_cmd   (front_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (back_cmd),
      .pop_ready  (pop_ready)
   );

   ngfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd       (back_cmd),
      .cmd_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- src/ngfe_checker.sv -----
// Port-level checks for the GGA sentence field extractor, bound to its top level.
`timescale 1ns / 1ps

module ngfe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [47:0] time_digits,
   input logic [7:0]  east_west,
   input logic        record_done
);

   // Out of reset the queue is empty and no response is pending.
   assert property (@(posedge clock) $past(reset) |-> req_ready && !rsp_valid)
      else $error("request side not ready or response pending after reset");

   // A completed record needs many characters, so two adjacent responses cannot both close one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && record_done |=> !(rsp_valid && rsp_ready && record_done))
      else $error("two consecutive responses both marked the record complete");

   // A stalled response keeps its record.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(time_digits) && $stable(east_west)
         && $stable(record_done))
      else $error("stalled response changed");

endmodule

bind nmea_gga_field_extractor_core ngfe_checker u_ngfe_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .time_digits (rsp_chan.time_digits),
   .east_west   (rsp_chan.east_west),
   .record_done (rsp_chan.record_done)
);
